// ----- design/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and helpers for the prefix match table
// Action codes, the write beat, the search token and the prefix length count.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// slots reachable through the 5-bit entry index
	localparam int INDEX_SPAN = 32;

	typedef struct packed {
		logic        valid;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [4:0]  metric;
		logic [5:0]  len;
	} wr_t;

	// search token walking the chain, one cell per cycle
	typedef struct packed {
		logic       active;
		logic       hit;
		logic [4:0] idx;
		logic [5:0] len;
	} token_t;

	// run of ones from bit 31 down: count leading zeros of the inverse
	function automatic logic [5:0] lead_ones(input logic [31:0] m);
		logic [31:0] x;
		logic [5:0]  n;
		x = ~m;
		n = 6'd0;
		if (x == 32'd0) begin
			n = 6'd32;
		end else begin
			if (x[31:16] == 16'd0) begin
				n = n + 6'd16;
				x = x << 16;
			end
			if (x[31:24] == 8'd0) begin
				n = n + 6'd8;
				x = x << 8;
			end
			if (x[31:28] == 4'd0) begin
				n = n + 6'd4;
				x = x << 4;
			end
			if (x[31:30] == 2'd0) begin
				n = n + 6'd2;
				x = x << 2;
			end
			if (x[31] == 1'b0) begin
				n = n + 6'd1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- design/lpm_cell.sv -----
// ----------------------------------------------------------------------------
// lpm_cell: one routing slot of the search chain
// Holds one entry and improves the passing token when its entry wins.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_cell #(
	parameter int CELL_INDEX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire logic [4:0]      wr_index,
	input  wire lpm_pkg::wr_t    wr,
	input  wire logic [31:0]     addr,
	input  wire logic [4:0]      thresh,
	input  wire lpm_pkg::token_t tok_in,
	output lpm_pkg::token_t      tok_out
);

	logic            valid_q;
	logic [31:0]     dest_q;
	logic [31:0]     mask_q;
	logic [4:0]      metric_q;
	logic [5:0]      len_q;
	logic            sel;
	logic            usable;
	logic            better;
	lpm_pkg::token_t tok_d;
	lpm_pkg::token_t tok_q;

	// slots past the index range are never written
	generate
		if (CELL_INDEX < lpm_pkg::INDEX_SPAN) begin : g_addr
			assign sel = wr_en && (wr_index == 5'(CELL_INDEX));
		end else begin : g_noaddr
			assign sel = 1'b0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			dest_q   <= wr.dest;
			mask_q   <= wr.mask;
			metric_q <= wr.metric;
			len_q    <= wr.len;
		end
	end

	always_comb begin
		usable = valid_q && (metric_q < thresh) && ((mask_q & addr) == (dest_q & mask_q));
		better = usable && (!tok_in.hit || (len_q > tok_in.len));
		tok_d  = tok_in;
		if (better) begin
			tok_d.hit = 1'b1;
			tok_d.idx = 5'(CELL_INDEX);
			tok_d.len = len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- design/longest_prefix_match_table_unit.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_table_unit: IPv4 longest prefix match routing table
// A row of slot cells; a lookup token walks the row and collects the best hit.
//
//  channel   signals                                  beat taken when
//  item      start, busy, action, entry_*, lookup_addr start & !busy
//  result    done, found, match_index, prefix_len     done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid & cfg_ready
//
// A write leaves busy low.
// A lookup raises busy; a launch register starts a token, which then steps
// through one cell per cycle; the result shows as it leaves the last cell,
// while busy is still high. The next beat is taken once busy drops.
// Reset clears every slot's valid bit and sets the unreachable limit to 16.
// The result cannot be stalled; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_match_table_unit #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [4:0]  entry_index,
	input  wire logic [31:0] entry_dest,
	input  wire logic [31:0] entry_mask,
	input  wire logic [4:0]  entry_metric,
	input  wire logic        entry_valid,
	input  wire logic [31:0] lookup_addr,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,
	output logic             done,
	output logic             found,
	output logic [4:0]       match_index,
	output logic [5:0]       prefix_len
);

	logic            accept;
	logic            wr_en;
	lpm_pkg::wr_t    wr;
	logic            busy_q;
	logic            launch_q;
	logic [31:0]     addr_q;
	logic [4:0]      thresh_q;
	lpm_pkg::token_t tok [TABLE_DEPTH+1];
	lpm_pkg::token_t last;

	assign accept = start && !busy_q;
	assign wr_en  = accept && (action == lpm_pkg::ACT_WRITE);

	assign wr.valid  = entry_valid;
	assign wr.dest   = entry_dest;
	assign wr.mask   = entry_mask;
	assign wr.metric = entry_metric;
	assign wr.len    = lpm_pkg::lead_ones(entry_mask);

	assign cfg_ready = 1'b1;
	assign last      = tok[TABLE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			thresh_q <= 5'd16;
		end else begin
			launch_q <= accept && (action == lpm_pkg::ACT_LOOKUP);
			if (accept && (action == lpm_pkg::ACT_LOOKUP)) begin
				busy_q <= 1'b1;
			end else if (last.active) begin
				busy_q <= 1'b0;
			end
			if (cfg_valid) begin
				thresh_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (action == lpm_pkg::ACT_LOOKUP)) begin
			addr_q <= lookup_addr;
		end
	end

	// fresh token enters the first cell
	assign tok[0] = '{active: launch_q, default: '0};

	generate
		for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			lpm_cell #(
				.CELL_INDEX(i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr_en   (wr_en),
				.wr_index(entry_index),
				.wr      (wr),
				.addr    (addr_q),
				.thresh  (thresh_q),
				.tok_in  (tok[i]),
				.tok_out (tok[i+1])
			);
		end
	endgenerate

	assign busy        = busy_q;
	assign done        = last.active;
	assign found       = last.hit;
	assign match_index = last.idx;
	assign prefix_len  = last.len;

endmodule

`default_nettype wire

// ----- design/lpm_checker.sv -----
// ----------------------------------------------------------------------------
// lpm_checker: port-level checks for the prefix match table
// Watches the item and result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        action,
	input wire logic        done,
	input wire logic        found,
	input wire logic [4:0]  match_index,
	input wire logic [5:0]  prefix_len
);

	// a result only ever closes a lookup still in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe with no lookup in flight");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == lpm_pkg::ACT_LOOKUP) |=> busy)
		else $error("lookup beat taken but busy not raised");

	// writes give no result and do not block the next beat
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == lpm_pkg::ACT_WRITE) |=> (!done && !busy))
		else $error("write beat produced a result or raised busy");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (match_index == 5'd0 && prefix_len == 6'd0))
		else $error("miss result carries non-zero index or length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (prefix_len <= 6'd32))
		else $error("prefix length beyond 32");

endmodule

bind longest_prefix_match_table_unit lpm_checker u_lpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.action     (action),
	.done       (done),
	.found      (found),
	.match_index(match_index),
	.prefix_len (prefix_len)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: longest prefix match routing table
// Fills a queue of table writes, lookups and limit changes, drives them with
// random gaps, predicts each lookup from a shadow table and checks every
// done beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE     = 4;
	localparam int DRAIN_WAIT = 40;

	typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} beat_kind_t;

	typedef struct {
		beat_kind_t  kind;
		logic        act;
		logic [4:0]  idx;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [4:0]  metric;
		logic        valid;
		logic [31:0] addr;
		logic [4:0]  limit;
		int          gap_pct;
	} stim_t;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
		logic [5:0] len;
	} route_hit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = lpm_pkg::ACT_WRITE;
	logic [4:0]  entry_index = '0;
	logic [31:0] entry_dest = '0;
	logic [31:0] entry_mask = '0;
	logic [4:0]  entry_metric = '0;
	logic        entry_valid = 1'b0;
	logic [31:0] lookup_addr = '0;
	logic        cfg_valid = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        busy, cfg_ready, done, found;
	logic [4:0]  match_index;
	logic [5:0]  prefix_len;

	stim_t      stim_q[$];
	route_hit_t hit_q[$];
	int         quiet = 0;
	int         errors = 0;

	// shadow of the routing table as the block should hold it
	logic        tbl_valid[lpm_pkg::INDEX_SPAN];
	logic [31:0] tbl_dest[lpm_pkg::INDEX_SPAN];
	logic [31:0] tbl_mask[lpm_pkg::INDEX_SPAN];
	logic [4:0]  tbl_metric[lpm_pkg::INDEX_SPAN];
	logic [4:0]  unreach = 5'd16;

	// what the generator has queued, used to aim lookups at real routes
	logic        gen_used[lpm_pkg::INDEX_SPAN];
	logic [31:0] gen_dest[lpm_pkg::INDEX_SPAN];
	logic [31:0] gen_mask[lpm_pkg::INDEX_SPAN];

	longest_prefix_match_table_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .entry_index(entry_index), .entry_dest(entry_dest),
		.entry_mask(entry_mask), .entry_metric(entry_metric),
		.entry_valid(entry_valid), .lookup_addr(lookup_addr),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .found(found), .match_index(match_index),
		.prefix_len(prefix_len)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int ones_run(logic [31:0] m);
		int n;
		n = 0;
		while (n < 32 && m[31 - n])
			n++;
		return n;
	endfunction

	function automatic route_hit_t lookup_route(logic [31:0] addr);
		route_hit_t r;
		int         len;
		int         i;
		r = '0;
		for (i = 0; i < lpm_pkg::INDEX_SPAN; i++) begin
			if (tbl_valid[i] && tbl_metric[i] < unreach &&
			    (tbl_mask[i] & addr) == (tbl_dest[i] & tbl_mask[i])) begin
				len = ones_run(tbl_mask[i]);
				// strictly longer only: ties keep the lower slot
				if (!r.found || len > r.len) begin
					r.found = 1'b1;
					r.idx   = i[4:0];
					r.len   = len[5:0];
				end
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] plen_mask(int len);
		logic [31:0] m;
		int          i;
		m = '0;
		for (i = 0; i < len; i++)
			m[31 - i] = 1'b1;
		return m;
	endfunction

	task automatic add_write(int idx, logic [31:0] dest, logic [31:0] mask,
	                         int metric, logic valid, int gap);
		stim_t s;
		s = '{kind: K_ITEM, act: lpm_pkg::ACT_WRITE, idx: idx[4:0], dest: dest,
		      mask: mask, metric: metric[4:0], valid: valid, addr: $urandom,
		      limit: '0, gap_pct: gap};
		stim_q.push_back(s);
		gen_used[idx] = valid;
		gen_dest[idx] = dest;
		gen_mask[idx] = mask;
	endtask

	task automatic add_lookup(logic [31:0] addr, int gap);
		stim_t s;
		s = '{kind: K_ITEM, act: lpm_pkg::ACT_LOOKUP, idx: 5'($urandom),
		      dest: $urandom, mask: $urandom, metric: 5'($urandom),
		      valid: 1'($urandom), addr: addr, limit: '0, gap_pct: gap};
		stim_q.push_back(s);
	endtask

	task automatic add_ctrl(beat_kind_t kind, int limit);
		stim_t s;
		s = '{kind: kind, act: lpm_pkg::ACT_WRITE, idx: '0, dest: '0, mask: '0,
		      metric: '0, valid: 1'b0, addr: '0, limit: limit[4:0], gap_pct: 0};
		stim_q.push_back(s);
	endtask

	function automatic logic [31:0] rand_mask();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom;
		else if (r < 15)
			return '0;
		else if (r < 22)
			return '1;
		return plen_mask($urandom_range(1, 31));
	endfunction

	task automatic add_rand_write(int gap);
		logic [31:0] m, d;
		int          met;
		m   = rand_mask();
		d   = $urandom;
		if ($urandom_range(1))
			d = d & m;
		met = ($urandom_range(99) < 70) ? $urandom_range(0, 20) : $urandom_range(0, 31);
		add_write($urandom_range(0, 31), d, m, met, $urandom_range(99) < 85, gap);
	endtask

	task automatic add_rand_lookup(int gap);
		int          k;
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(99) < 75) begin
			k = $urandom_range(0, 31);
			if (gen_used[k])
				a = (gen_dest[k] & gen_mask[k]) | (a & ~gen_mask[k]);
		end
		add_lookup(a, gap);
	endtask

	// driver: launches queued beats, predicts each lookup at acceptance
	always @(posedge clk or negedge arst_n) begin
		logic  hold, n_start, n_cfgv;
		stim_t s;
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
			quiet     <= 0;
		end else begin
			if (start && !busy) begin
				if (action == lpm_pkg::ACT_WRITE) begin
					tbl_valid[entry_index]  = entry_valid;
					tbl_dest[entry_index]   = entry_dest;
					tbl_mask[entry_index]   = entry_mask;
					tbl_metric[entry_index] = entry_metric;
				end else begin
					hit_q.push_back(lookup_route(lookup_addr));
				end
			end
			if (cfg_valid && cfg_ready)
				unreach = cfg_data;

			if (hit_q.size() == 0 && !busy && !start && !cfg_valid)
				quiet <= quiet + 1;
			else
				quiet <= 0;

			hold    = (start && busy) || (cfg_valid && !cfg_ready);
			n_start = hold ? start : 1'b0;
			n_cfgv  = hold ? cfg_valid : 1'b0;
			if (!hold && stim_q.size() > 0) begin
				s = stim_q[0];
				case (s.kind)
					K_ITEM: begin
						if ($urandom_range(99) >= s.gap_pct) begin
							void'(stim_q.pop_front());
							action       <= s.act;
							entry_index  <= s.idx;
							entry_dest   <= s.dest;
							entry_mask   <= s.mask;
							entry_metric <= s.metric;
							entry_valid  <= s.valid;
							lookup_addr  <= s.addr;
							n_start      = 1'b1;
						end
					end
					K_CFG: begin
						// limit only changes once the table has gone quiet
						if (quiet >= SETTLE) begin
							void'(stim_q.pop_front());
							cfg_data <= s.limit;
							n_cfgv   = 1'b1;
						end
					end
					default: begin
						if (quiet >= 1)
							void'(stim_q.pop_front());
					end
				endcase
			end
			start     <= n_start;
			cfg_valid <= n_cfgv;
		end
	end

	// monitor: each done beat against the oldest prediction
	always @(posedge clk) begin
		route_hit_t e;
		if (arst_n && done) begin
			if (hit_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at %0t: found %0b idx %0d len %0d",
					         $realtime, found, match_index, prefix_len);
			end else begin
				e = hit_q.pop_front();
				if (e.found !== found || e.idx !== match_index || e.len !== prefix_len) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch at %0t: exp found %0b idx %0d len %0d,",
						          " got found %0b idx %0d len %0d"},
						         $realtime, e.found, e.idx, e.len, found, match_index,
						         prefix_len);
				end
			end
		end
	end

	initial begin
		int          gaps[3];
		int          ph, seg, n, r;
		logic [4:0]  limits[9];
		for (n = 0; n < lpm_pkg::INDEX_SPAN; n++) begin
			tbl_valid[n]  = 1'b0;
			tbl_dest[n]   = '0;
			tbl_mask[n]   = '0;
			tbl_metric[n] = '0;
			gen_used[n]   = 1'b0;
			gen_dest[n]   = '0;
			gen_mask[n]   = '0;
		end

		// directed: empty table, default route, host route, ties,
		// unreachable metrics, removal, non-contiguous mask, limit extremes
		add_lookup(32'h0A00_0001, 0);
		add_write(0, 32'h0000_0000, 32'h0000_0000, 0, 1'b1, 0);
		add_write(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, 1'b1, 0);
		add_write(5, 32'h0A00_0000, plen_mask(8), 1, 1'b1, 0);
		add_write(9, 32'h0A00_0000, plen_mask(8), 2, 1'b1, 0);
		add_write(6, 32'h0A01_0000, plen_mask(16), 16, 1'b1, 0);
		add_write(7, 32'h0A01_0003, 32'hFFFF_00FF, 3, 1'b1, 0);
		add_write(20, 32'hC0A8_0100, plen_mask(24), 31, 1'b1, 0);
		add_write(21, 32'hC0A8_0000, plen_mask(16), 0, 1'b0, 0);
		add_lookup(32'hFFFF_FFFF, 0);
		add_lookup(32'h0A01_0203, 0);
		add_lookup(32'h0A01_0204, 0);
		add_lookup(32'hC0A8_0101, 0);
		add_lookup(32'h0000_0000, 0);
		add_ctrl(K_CFG, 31);
		add_lookup(32'h0A01_0204, 0);
		add_write(0, 32'h0000_0000, 32'h0000_0000, 0, 1'b0, 0);
		add_lookup(32'hC0A8_0101, 0);
		add_ctrl(K_CFG, 0);
		add_lookup(32'hFFFF_FFFF, 0);
		add_ctrl(K_CFG, 16);
		add_write(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, 1'b0, 0);
		add_lookup(32'hFFFF_FFFF, 0);
		add_lookup(32'h0A7F_0000, 0);

		gaps   = '{34, 53, 0};
		limits = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd30, 5'($urandom), 5'd8,
		           5'($urandom), 5'd16};
		for (ph = 0; ph < 3; ph++) begin
			for (seg = 0; seg < 3; seg++) begin
				add_ctrl(K_CFG, limits[ph * 3 + seg]);
				for (n = 0; n < 125; n++) begin
					r = $urandom_range(99);
					if (r < 3)
						add_ctrl(K_DRAIN, 0);
					if (r < 35)
						add_rand_write(gaps[ph]);
					else
						add_rand_lookup(gaps[ph]);
				end
			end
		end
		add_ctrl(K_DRAIN, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (stim_q.size() != 0 || start || cfg_valid);
		while (hit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#8ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
design/lpm_pkg.sv
design/lpm_cell.sv
design/longest_prefix_match_table_unit.sv
design/lpm_checker.sv
tb/testbench.sv
